// ===== src/lpg_pkg.sv =====
// Shared types and constants for the line point generator.
`default_nettype none
package lpg_pkg;

	localparam int COORD_W = 6;              // fixed width of coordinate fields on the ports
	localparam int ERR_W   = COORD_W + 2;    // signed Bresenham error, widest case
	localparam int SEG_FIFO_DEPTH = 2;       // line setups queued between front and walker

	typedef logic [COORD_W-1:0] coord_t;

	// One line request beat.
	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} line_req_t;

	// One emitted point beat.
	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		logic   last_point;
	} line_pt_t;

	// Setup of one line, handed from front to walker.
	typedef struct packed {
		coord_t           cur_x;
		coord_t           cur_y;
		coord_t           end_x;
		coord_t           end_y;
		coord_t           abs_dx;
		coord_t           abs_dy;
		logic             neg_x;   // x steps down
		logic             neg_y;   // y steps down
		logic [ERR_W-1:0] err;     // initial error, two's complement
	} seg_setup_t;

	localparam int SEG_W = $bits(seg_setup_t);

endpackage
`default_nettype wire

// ===== src/lpg_front.sv =====
// Front end: masks request coordinates and computes the line setup.
`default_nettype none
module lpg_front import lpg_pkg::*; #(
	parameter int COORD_BITS = 6
) (
	input  wire line_req_t  req,
	output seg_setup_t      setup
);

	localparam int CW = COORD_BITS;

	logic [CW-1:0] sx, sy, ex, ey;
	logic [CW-1:0] adx, ady;
	logic          x_fwd, y_fwd;

	always_comb begin
		sx = req.start_x[CW-1:0];
		sy = req.start_y[CW-1:0];
		ex = req.end_x[CW-1:0];
		ey = req.end_y[CW-1:0];
		x_fwd = sx < ex;
		y_fwd = sy < ey;
		adx = x_fwd ? (ex - sx) : (sx - ex);
		ady = y_fwd ? (ey - sy) : (sy - ey);

		setup.cur_x  = COORD_W'(sx);
		setup.cur_y  = COORD_W'(sy);
		setup.end_x  = COORD_W'(ex);
		setup.end_y  = COORD_W'(ey);
		setup.abs_dx = COORD_W'(adx);
		setup.abs_dy = COORD_W'(ady);
		setup.neg_x  = ~x_fwd;
		setup.neg_y  = ~y_fwd;
		setup.err    = ERR_W'(adx) - ERR_W'(ady);
	end

endmodule
`default_nettype wire

// ===== src/lpg_seg_fifo.sv =====
// Small register queue of line setups between front and walker.
`default_nettype none
module lpg_seg_fifo import lpg_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        wr_en,
	input  wire seg_setup_t wr_data,
	output logic       full,
	input  wire        rd_en,
	output seg_setup_t rd_data,
	output logic       empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	seg_setup_t      mem_q [DEPTH];
	logic [AW:0]     wptr_q, rptr_q;

	assign empty   = (wptr_q == rptr_q);
	assign full    = (wptr_q[AW-1:0] == rptr_q[AW-1:0]) && (wptr_q[AW] != rptr_q[AW]);
	assign rd_data = mem_q[rptr_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (wr_en && !full)
				wptr_q <= wptr_q + 1'b1;
			if (rd_en && !empty)
				rptr_q <= rptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !full)
			mem_q[wptr_q[AW-1:0]] <= wr_data;
	end

endmodule
`default_nettype wire

// ===== src/lpg_walker.sv =====
// Back end: walks one Bresenham line a point per cycle into an output register, while that register is free.
`default_nettype none
module lpg_walker import lpg_pkg::*; #(
	parameter int COORD_BITS = 6
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire seg_setup_t seg,
	input  wire        seg_empty,
	output logic       seg_pop,
	output line_pt_t   pt,
	output logic       empty,
	input  wire        pop
);

	localparam int CW = COORD_BITS;
	localparam int EW = CW + 2;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} walk_state_t;

	walk_state_t    state_q;
	logic [CW-1:0]  cur_x_q, cur_y_q, end_x_q, end_y_q, adx_q, ady_q;
	logic           neg_x_q, neg_y_q;
	logic [EW-1:0]  err_q;
	logic           out_valid_q;
	line_pt_t       out_q;

	logic           slot_free, at_end, step_x, step_y;
	logic signed [EW:0] e2, dx_s, dy_s;
	logic [EW-1:0]  err_nxt;

	assign slot_free = !out_valid_q || pop;
	assign at_end    = (cur_x_q == end_x_q) && (cur_y_q == end_y_q);
	assign seg_pop   = (state_q == ST_IDLE) && !seg_empty;
	assign empty     = !out_valid_q;
	assign pt        = out_q;

	always_comb begin
		e2     = $signed({err_q, 1'b0});
		dx_s   = $signed({3'b000, adx_q});
		dy_s   = -$signed({3'b000, ady_q});
		step_x = (e2 >= dy_s);
		step_y = (e2 <= dx_s);
		err_nxt = err_q
			+ (step_x ? (EW'(0) - EW'(ady_q)) : EW'(0))
			+ (step_y ? EW'(adx_q) : EW'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_WALK && slot_free)
				out_valid_q <= 1'b1;
			else if (pop && out_valid_q)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!seg_empty)
						state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (slot_free && at_end)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (seg_pop) begin
			cur_x_q <= seg.cur_x[CW-1:0];
			cur_y_q <= seg.cur_y[CW-1:0];
			end_x_q <= seg.end_x[CW-1:0];
			end_y_q <= seg.end_y[CW-1:0];
			adx_q   <= seg.abs_dx[CW-1:0];
			ady_q   <= seg.abs_dy[CW-1:0];
			neg_x_q <= seg.neg_x;
			neg_y_q <= seg.neg_y;
			err_q   <= seg.err[EW-1:0];
		end else if (state_q == ST_WALK && slot_free) begin
			out_q.point_x    <= COORD_W'(cur_x_q);
			out_q.point_y    <= COORD_W'(cur_y_q);
			out_q.last_point <= at_end;
			err_q <= err_nxt;
			if (step_x)
				cur_x_q <= neg_x_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
			if (step_y)
				cur_y_q <= neg_y_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== src/line_point_generator_core.sv =====
// Top level of the Bresenham line point generator.
// Request path: setup queue, then walker load, then first point registered on pt.
// Throughput: max(|dx|,|dy|)+1 point beats per line, one per cycle unless pt is stalled,
//   and a walker load per line; the two-line setup queue lets requests be taken while a walk runs.
// Reset: arst_n clears the queue pointers, walker state and output valid; no points pending.
`default_nettype none
module line_point_generator_core import lpg_pkg::*; #(
	parameter int COORD_BITS = 6
) (
	input  wire        clk,
	input  wire        arst_n,
	// request side: one beat per line
	input  wire        push,
	output logic       full,
	input  wire line_req_t req,
	// point side: one beat per point, last_point marks the end point
	output logic       empty,
	input  wire        pop,
	output line_pt_t   pt
);

	seg_setup_t setup, seg;
	logic       seg_empty, seg_pop;

	// front: coordinate masking, deltas, step directions, initial error
	lpg_front #(.COORD_BITS(COORD_BITS)) u_front (
		.req   (req),
		.setup (setup)
	);

	// decouples request intake from the point walk
	lpg_seg_fifo #(.DEPTH(SEG_FIFO_DEPTH)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (setup),
		.full    (full),
		.rd_en   (seg_pop),
		.rd_data (seg),
		.empty   (seg_empty)
	);

	// back: one error update and step per point, registered output beat
	lpg_walker #(.COORD_BITS(COORD_BITS)) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg       (seg),
		.seg_empty (seg_empty),
		.seg_pop   (seg_pop),
		.pt        (pt),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
`default_nettype wire
